[design/esc_pkg.sv]
// ----------------------------------------------------------------------------
// esc_pkg: shared types, codes and microprogram
// Operation and operand codes, the instruction word and the fixed program that
// the compensation sequencer steps through for each burst.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int unsigned PcW = 7;

  // operation codes
  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_MUL  = 4'd2;
  localparam logic [3:0] OP_SHL  = 4'd3;
  localparam logic [3:0] OP_DIVP = 4'd4;
  localparam logic [3:0] OP_DIV  = 4'd5;
  localparam logic [3:0] OP_CLMP = 4'd6;
  localparam logic [3:0] OP_FINE = 4'd7;
  localparam logic [3:0] OP_END  = 4'd8;

  // register destinations
  localparam logic [2:0] D0 = 3'd0;
  localparam logic [2:0] D1 = 3'd1;
  localparam logic [2:0] D2 = 3'd2;
  localparam logic [2:0] D3 = 3'd3;
  localparam logic [2:0] D4 = 3'd4;
  localparam logic [2:0] D5 = 3'd5;
  localparam logic [2:0] D6 = 3'd6;
  localparam logic [2:0] D7 = 3'd7;

  // operand sources
  localparam logic [5:0] S_R0 = 6'd0;
  localparam logic [5:0] S_R1 = 6'd1;
  localparam logic [5:0] S_R2 = 6'd2;
  localparam logic [5:0] S_R3 = 6'd3;
  localparam logic [5:0] S_R6 = 6'd6;
  localparam logic [5:0] S_T1 = 6'd8;
  localparam logic [5:0] S_T2 = 6'd9;
  localparam logic [5:0] S_T3 = 6'd10;
  localparam logic [5:0] S_P1 = 6'd11;
  localparam logic [5:0] S_P2 = 6'd12;
  localparam logic [5:0] S_P3 = 6'd13;
  localparam logic [5:0] S_P4 = 6'd14;
  localparam logic [5:0] S_P5 = 6'd15;
  localparam logic [5:0] S_P6 = 6'd16;
  localparam logic [5:0] S_P7 = 6'd17;
  localparam logic [5:0] S_P8 = 6'd18;
  localparam logic [5:0] S_P9 = 6'd19;
  localparam logic [5:0] S_H1 = 6'd20;
  localparam logic [5:0] S_H2 = 6'd21;
  localparam logic [5:0] S_H3 = 6'd22;
  localparam logic [5:0] S_H4 = 6'd23;
  localparam logic [5:0] S_H5 = 6'd24;
  localparam logic [5:0] S_H6 = 6'd25;
  localparam logic [5:0] S_ADCT = 6'd26;
  localparam logic [5:0] S_ADCP = 6'd27;
  localparam logic [5:0] S_RAWH = 6'd28;
  localparam logic [5:0] S_FINE = 6'd29;
  localparam logic [5:0] S_K5 = 6'd30;
  localparam logic [5:0] S_K3125 = 6'd31;
  localparam logic [5:0] S_K128 = 6'd32;
  localparam logic [5:0] S_K8192 = 6'd33;
  localparam logic [5:0] S_K16384 = 6'd34;
  localparam logic [5:0] S_K32768 = 6'd35;
  localparam logic [5:0] S_K76800 = 6'd36;
  localparam logic [5:0] S_K128000 = 6'd37;
  localparam logic [5:0] S_K1048576 = 6'd38;
  localparam logic [5:0] S_K2097152 = 6'd39;
  localparam logic [5:0] S_K2P47 = 6'd40;

  // configuration register indexes
  localparam logic [2:0] REG_CAL_TEMP  = 3'd0;
  localparam logic [2:0] REG_PRESS_LO  = 3'd1;
  localparam logic [2:0] REG_PRESS_HI  = 3'd2;
  localparam logic [2:0] REG_PRESS_9   = 3'd3;
  localparam logic [2:0] REG_HUM_LO    = 3'd4;
  localparam logic [2:0] REG_HUM_HI    = 3'd5;

  localparam logic [23:0] TEMP_INVALID = 24'h800000;
  localparam logic [15:0] HUM_INVALID  = 16'h8000;
  localparam logic signed [63:0] HUM_MAX = 64'sd419430400;

  typedef struct packed {
    logic [3:0] op;
    logic       w;    // wrap result to 32 bits
    logic [2:0] dst;
    logic [5:0] a;
    logic [5:0] b;
    logic [5:0] sh;
  } instr_t;

  function automatic instr_t mk(input logic [3:0] op, input logic w, input logic [2:0] dst,
                                input logic [5:0] a, input logic [5:0] b,
                                input logic [5:0] sh);
    instr_t i;
    i.op = op; i.w = w; i.dst = dst; i.a = a; i.b = b; i.sh = sh;
    return i;
  endfunction

  // compensation microprogram
  function automatic instr_t prog(input logic [PcW-1:0] pc);
    instr_t i;
    case (pc)
      // temperature, 32-bit wrap
      7'd0:  i = mk(OP_DIVP, 1'b0, D0, S_ADCT, S_R0, 6'd3);
      7'd1:  i = mk(OP_SHL,  1'b0, D1, S_T1, S_R0, 6'd1);
      7'd2:  i = mk(OP_SUB,  1'b1, D0, S_R0, S_R1, 6'd0);
      7'd3:  i = mk(OP_MUL,  1'b1, D0, S_R0, S_T2, 6'd0);
      7'd4:  i = mk(OP_DIVP, 1'b0, D0, S_R0, S_R0, 6'd11);
      7'd5:  i = mk(OP_DIVP, 1'b0, D1, S_ADCT, S_R0, 6'd4);
      7'd6:  i = mk(OP_SUB,  1'b1, D1, S_R1, S_T1, 6'd0);
      7'd7:  i = mk(OP_MUL,  1'b1, D1, S_R1, S_R1, 6'd0);
      7'd8:  i = mk(OP_DIVP, 1'b0, D1, S_R1, S_R0, 6'd12);
      7'd9:  i = mk(OP_MUL,  1'b1, D1, S_R1, S_T3, 6'd0);
      7'd10: i = mk(OP_DIVP, 1'b0, D1, S_R1, S_R0, 6'd14);
      7'd11: i = mk(OP_ADD,  1'b1, D2, S_R0, S_R1, 6'd0);
      7'd12: i = mk(OP_FINE, 1'b0, D0, S_R2, S_R0, 6'd0);
      7'd13: i = mk(OP_MUL,  1'b1, D0, S_R2, S_K5, 6'd0);
      7'd14: i = mk(OP_ADD,  1'b1, D0, S_R0, S_K128, 6'd0);
      7'd15: i = mk(OP_DIVP, 1'b0, D7, S_R0, S_R0, 6'd8);
      // pressure, 64-bit
      7'd16: i = mk(OP_SUB,  1'b0, D0, S_FINE, S_K128000, 6'd0);
      7'd17: i = mk(OP_MUL,  1'b0, D1, S_R0, S_R0, 6'd0);
      7'd18: i = mk(OP_MUL,  1'b0, D2, S_R1, S_P6, 6'd0);
      7'd19: i = mk(OP_MUL,  1'b0, D3, S_R0, S_P5, 6'd0);
      7'd20: i = mk(OP_SHL,  1'b0, D3, S_R3, S_R0, 6'd17);
      7'd21: i = mk(OP_ADD,  1'b0, D2, S_R2, S_R3, 6'd0);
      7'd22: i = mk(OP_SHL,  1'b0, D3, S_P4, S_R0, 6'd35);
      7'd23: i = mk(OP_ADD,  1'b0, D2, S_R2, S_R3, 6'd0);
      7'd24: i = mk(OP_MUL,  1'b0, D1, S_R1, S_P3, 6'd0);
      7'd25: i = mk(OP_DIVP, 1'b0, D1, S_R1, S_R0, 6'd8);
      7'd26: i = mk(OP_MUL,  1'b0, D3, S_R0, S_P2, 6'd0);
      7'd27: i = mk(OP_SHL,  1'b0, D3, S_R3, S_R0, 6'd12);
      7'd28: i = mk(OP_ADD,  1'b0, D1, S_R1, S_R3, 6'd0);
      7'd29: i = mk(OP_ADD,  1'b0, D1, S_R1, S_K2P47, 6'd0);
      7'd30: i = mk(OP_MUL,  1'b0, D1, S_R1, S_P1, 6'd0);
      7'd31: i = mk(OP_DIVP, 1'b0, D6, S_R1, S_R0, 6'd33);
      7'd32: i = mk(OP_SUB,  1'b0, D0, S_K1048576, S_ADCP, 6'd0);
      7'd33: i = mk(OP_SHL,  1'b0, D0, S_R0, S_R0, 6'd31);
      7'd34: i = mk(OP_SUB,  1'b0, D0, S_R0, S_R2, 6'd0);
      7'd35: i = mk(OP_MUL,  1'b0, D0, S_R0, S_K3125, 6'd0);
      7'd36: i = mk(OP_DIV,  1'b0, D0, S_R0, S_R6, 6'd0);
      7'd37: i = mk(OP_DIVP, 1'b0, D1, S_R0, S_R0, 6'd13);
      7'd38: i = mk(OP_MUL,  1'b0, D2, S_R1, S_P9, 6'd0);
      7'd39: i = mk(OP_MUL,  1'b0, D2, S_R2, S_R1, 6'd0);
      7'd40: i = mk(OP_DIVP, 1'b0, D2, S_R2, S_R0, 6'd25);
      7'd41: i = mk(OP_MUL,  1'b0, D3, S_R0, S_P8, 6'd0);
      7'd42: i = mk(OP_DIVP, 1'b0, D3, S_R3, S_R0, 6'd19);
      7'd43: i = mk(OP_ADD,  1'b0, D0, S_R0, S_R2, 6'd0);
      7'd44: i = mk(OP_ADD,  1'b0, D0, S_R0, S_R3, 6'd0);
      7'd45: i = mk(OP_DIVP, 1'b0, D0, S_R0, S_R0, 6'd8);
      7'd46: i = mk(OP_SHL,  1'b0, D3, S_P7, S_R0, 6'd4);
      7'd47: i = mk(OP_ADD,  1'b0, D5, S_R0, S_R3, 6'd0);
      // humidity, 32-bit wrap
      7'd48: i = mk(OP_SUB,  1'b1, D0, S_FINE, S_K76800, 6'd0);
      7'd49: i = mk(OP_SHL,  1'b1, D1, S_RAWH, S_R0, 6'd14);
      7'd50: i = mk(OP_SHL,  1'b1, D2, S_H4, S_R0, 6'd20);
      7'd51: i = mk(OP_SUB,  1'b1, D1, S_R1, S_R2, 6'd0);
      7'd52: i = mk(OP_MUL,  1'b1, D2, S_H5, S_R0, 6'd0);
      7'd53: i = mk(OP_SUB,  1'b1, D1, S_R1, S_R2, 6'd0);
      7'd54: i = mk(OP_ADD,  1'b1, D1, S_R1, S_K16384, 6'd0);
      7'd55: i = mk(OP_DIVP, 1'b0, D1, S_R1, S_R0, 6'd15);
      7'd56: i = mk(OP_MUL,  1'b1, D2, S_R0, S_H6, 6'd0);
      7'd57: i = mk(OP_DIVP, 1'b0, D2, S_R2, S_R0, 6'd10);
      7'd58: i = mk(OP_MUL,  1'b1, D3, S_R0, S_H3, 6'd0);
      7'd59: i = mk(OP_DIVP, 1'b0, D3, S_R3, S_R0, 6'd11);
      7'd60: i = mk(OP_ADD,  1'b1, D3, S_R3, S_K32768, 6'd0);
      7'd61: i = mk(OP_MUL,  1'b1, D2, S_R2, S_R3, 6'd0);
      7'd62: i = mk(OP_DIVP, 1'b0, D2, S_R2, S_R0, 6'd10);
      7'd63: i = mk(OP_ADD,  1'b1, D2, S_R2, S_K2097152, 6'd0);
      7'd64: i = mk(OP_MUL,  1'b1, D2, S_R2, S_H2, 6'd0);
      7'd65: i = mk(OP_ADD,  1'b1, D2, S_R2, S_K8192, 6'd0);
      7'd66: i = mk(OP_DIVP, 1'b0, D2, S_R2, S_R0, 6'd14);
      7'd67: i = mk(OP_MUL,  1'b1, D1, S_R1, S_R2, 6'd0);
      7'd68: i = mk(OP_DIVP, 1'b0, D2, S_R1, S_R0, 6'd15);
      7'd69: i = mk(OP_MUL,  1'b1, D2, S_R2, S_R2, 6'd0);
      7'd70: i = mk(OP_DIVP, 1'b0, D2, S_R2, S_R0, 6'd7);
      7'd71: i = mk(OP_MUL,  1'b1, D2, S_R2, S_H1, 6'd0);
      7'd72: i = mk(OP_DIVP, 1'b0, D2, S_R2, S_R0, 6'd4);
      7'd73: i = mk(OP_SUB,  1'b1, D1, S_R1, S_R2, 6'd0);
      7'd74: i = mk(OP_CLMP, 1'b0, D1, S_R1, S_R0, 6'd0);
      7'd75: i = mk(OP_DIVP, 1'b0, D4, S_R1, S_R0, 6'd12);
      default: i = mk(OP_END, 1'b0, D0, S_R0, S_R0, 6'd0);
    endcase
    return i;
  endfunction

endpackage

[design/esc_if.sv]
// ----------------------------------------------------------------------------
// esc_if: sensor burst and result channels
// Valid/ready channels for the raw burst going in and the compensated
// readings coming out.
// ----------------------------------------------------------------------------
interface esc_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] raw_temp;
  logic [23:0] raw_press;
  logic [15:0] raw_hum;
  modport source (output valid, raw_temp, raw_press, raw_hum, input ready);
  modport sink   (input valid, raw_temp, raw_press, raw_hum, output ready);
endinterface

interface esc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temp_centi;
  logic               temp_valid;
  logic signed [63:0] press_q24_8;
  logic               press_valid;
  logic [16:0]        hum_q22_10;
  logic               hum_valid;
  modport source (output valid, temp_centi, temp_valid, press_q24_8, press_valid,
                  hum_q22_10, hum_valid, input ready);
  modport sink   (input valid, temp_centi, temp_valid, press_q24_8, press_valid,
                  hum_q22_10, hum_valid, output ready);
endinterface

[design/environment_sensor_compensation_top.sv]
// ----------------------------------------------------------------------------
// environment_sensor_compensation_top: barometric sensor compensation
// Microcoded sequencer around one shared datapath: adder, shifter, a 32x32
// multiplier reused for the partial products of each 64-bit product and a radix-2 divider.
// ----------------------------------------------------------------------------
// channel   dir  handshake      beat contents
// sens_i    in   valid/ready    raw_temp, raw_press, raw_hum
// res_o     out  valid/ready    temp, pressure, humidity and their flags
// cfg       in   cfg_we_i       cfg_idx_i selects register, cfg_data_i value
//
// a burst runs 77 microinstructions from its accepting edge to a valid result,
// among them 22 multiplies on the shared 32x32 multiplier and the pressure
// divide on the divider
// ready is high only when the sequencer is idle, so a new burst is not taken
// while one is running; a finished result waits in the output register and the
// next burst may start behind it, stalling only at its last step
// reset clears calibration, fine temperature and all control state
// ----------------------------------------------------------------------------
module environment_sensor_compensation_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  esc_in_if.sink      sens_i,
  esc_out_if.source   res_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;

  logic [1:0]  state_q;
  logic [esc_pkg::PcW-1:0] pc_q;
  logic [6:0]  cnt_q;

  logic [47:0] cal_t_q;
  logic [63:0] cal_pl_q, cal_ph_q;
  logic [15:0] cal_p9_q;
  logic [31:0] cal_hl_q, cal_hh_q;
  logic signed [31:0] fine_q;

  logic [23:0] raw_t_q, raw_p_q;
  logic [15:0] raw_h_q;

  logic signed [63:0] rf_q [8];

  // multiplier and divider state
  logic [63:0] prod_q, acc_q;
  logic [63:0] dv_rem_q, dv_quo_q, dv_den_q;
  logic        dv_neg_q, dv_zero_q;

  logic out_vld_q;

  esc_pkg::instr_t ins;
  logic signed [63:0] a_val, b_val, alu_res, wb_val;
  logic        step_done, wb_en;
  logic        fin_done;

  // operand selection
  function automatic logic signed [63:0] src(input logic [5:0] s);
    logic signed [63:0] v;
    case (s)
      esc_pkg::S_T1: v = {48'd0, cal_t_q[15:0]};
      esc_pkg::S_T2: v = {{48{cal_t_q[31]}}, cal_t_q[31:16]};
      esc_pkg::S_T3: v = {{48{cal_t_q[47]}}, cal_t_q[47:32]};
      esc_pkg::S_P1: v = {48'd0, cal_pl_q[15:0]};
      esc_pkg::S_P2: v = {{48{cal_pl_q[31]}}, cal_pl_q[31:16]};
      esc_pkg::S_P3: v = {{48{cal_pl_q[47]}}, cal_pl_q[47:32]};
      esc_pkg::S_P4: v = {{48{cal_pl_q[63]}}, cal_pl_q[63:48]};
      esc_pkg::S_P5: v = {{48{cal_ph_q[15]}}, cal_ph_q[15:0]};
      esc_pkg::S_P6: v = {{48{cal_ph_q[31]}}, cal_ph_q[31:16]};
      esc_pkg::S_P7: v = {{48{cal_ph_q[47]}}, cal_ph_q[47:32]};
      esc_pkg::S_P8: v = {{48{cal_ph_q[63]}}, cal_ph_q[63:48]};
      esc_pkg::S_P9: v = {{48{cal_p9_q[15]}}, cal_p9_q};
      esc_pkg::S_H1: v = {56'd0, cal_hl_q[7:0]};
      esc_pkg::S_H2: v = {{48{cal_hl_q[23]}}, cal_hl_q[23:8]};
      esc_pkg::S_H3: v = {56'd0, cal_hl_q[31:24]};
      esc_pkg::S_H4: v = {52'd0, cal_hh_q[11:0]};
      esc_pkg::S_H5: v = {52'd0, cal_hh_q[23:12]};
      esc_pkg::S_H6: v = {{56{cal_hh_q[31]}}, cal_hh_q[31:24]};
      esc_pkg::S_ADCT: v = {44'd0, raw_t_q[23:4]};
      esc_pkg::S_ADCP: v = {44'd0, raw_p_q[23:4]};
      esc_pkg::S_RAWH: v = {48'd0, raw_h_q};
      esc_pkg::S_FINE: v = {{32{fine_q[31]}}, fine_q};
      esc_pkg::S_K5: v = 64'sd5;
      esc_pkg::S_K3125: v = 64'sd3125;
      esc_pkg::S_K128: v = 64'sd128;
      esc_pkg::S_K8192: v = 64'sd8192;
      esc_pkg::S_K16384: v = 64'sd16384;
      esc_pkg::S_K32768: v = 64'sd32768;
      esc_pkg::S_K76800: v = 64'sd76800;
      esc_pkg::S_K128000: v = 64'sd128000;
      esc_pkg::S_K1048576: v = 64'sd1048576;
      esc_pkg::S_K2097152: v = 64'sd2097152;
      esc_pkg::S_K2P47: v = 64'sd140737488355328;
      default: v = rf_q[s[2:0]];
    endcase
    return v;
  endfunction

  assign ins = esc_pkg::prog(pc_q);

  // operand fetch
  always_comb begin
    a_val = src(ins.a);
    b_val = src(ins.b);
  end

  // shared datapath and step completion
  always_comb begin
    logic [63:0] bias;
    logic [63:0] q;
    bias      = ~(64'hFFFF_FFFF_FFFF_FFFF << ins.sh);
    q         = dv_neg_q ? (64'd0 - dv_quo_q) : dv_quo_q;
    alu_res   = a_val;
    step_done = 1'b1;
    wb_en     = 1'b1;
    case (ins.op)
      esc_pkg::OP_ADD:  alu_res = a_val + b_val;
      esc_pkg::OP_SUB:  alu_res = a_val - b_val;
      esc_pkg::OP_SHL:  alu_res = a_val <<< ins.sh;
      esc_pkg::OP_DIVP: alu_res = (a_val + (a_val[63] ? $signed(bias) : 64'sd0)) >>> ins.sh;
      esc_pkg::OP_CLMP: begin
        if (a_val[63]) begin
          alu_res = 64'sd0;
        end else if (a_val > esc_pkg::HUM_MAX) begin
          alu_res = esc_pkg::HUM_MAX;
        end
      end
      esc_pkg::OP_MUL: begin
        step_done = (cnt_q == 7'd3);
        alu_res   = $signed(acc_q + {prod_q[31:0], 32'd0});
      end
      esc_pkg::OP_DIV: begin
        step_done = (cnt_q == 7'd65);
        alu_res   = dv_zero_q ? 64'sd0 : $signed(q);
      end
      esc_pkg::OP_FINE: wb_en = 1'b0;
      esc_pkg::OP_END: begin
        wb_en     = 1'b0;
        step_done = !out_vld_q || res_o.ready;
      end
      default: wb_en = 1'b0;
    endcase
    wb_val = ins.w ? {{32{alu_res[31]}}, alu_res[31:0]} : alu_res;
  end

  assign sens_i.ready = (state_q == ST_IDLE);

  // last step of a burst loads the result register
  assign fin_done = (state_q == ST_RUN) && (ins.op == esc_pkg::OP_END) && step_done;

  // sequencer, calibration and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pc_q      <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
      fine_q    <= '0;
      cal_t_q   <= '0;
      cal_pl_q  <= '0;
      cal_ph_q  <= '0;
      cal_p9_q  <= '0;
      cal_hl_q  <= '0;
      cal_hh_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          esc_pkg::REG_CAL_TEMP: cal_t_q  <= cfg_data_i[47:0];
          esc_pkg::REG_PRESS_LO: cal_pl_q <= cfg_data_i;
          esc_pkg::REG_PRESS_HI: cal_ph_q <= cfg_data_i;
          esc_pkg::REG_PRESS_9:  cal_p9_q <= cfg_data_i[15:0];
          esc_pkg::REG_HUM_LO:   cal_hl_q <= cfg_data_i[31:0];
          esc_pkg::REG_HUM_HI:   cal_hh_q <= cfg_data_i[31:0];
          default: ;
        endcase
      end
      if (fin_done) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && res_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (sens_i.valid) begin
            state_q <= ST_RUN;
            pc_q    <= '0;
            cnt_q   <= '0;
          end
        end
        ST_RUN: begin
          if (ins.op == esc_pkg::OP_FINE && raw_t_q != esc_pkg::TEMP_INVALID) begin
            fine_q <= a_val[31:0];
          end
          if (step_done) begin
            cnt_q <= '0;
            pc_q  <= pc_q + 1'b1;
            if (ins.op == esc_pkg::OP_END) begin
              state_q <= ST_IDLE;
            end
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // burst capture, register file, multiplier, divider and result register
  always_ff @(posedge clk_i) begin
    logic [64:0] rem_sh;
    rem_sh = {dv_rem_q, dv_quo_q[63]};
    if (sens_i.valid && sens_i.ready) begin
      raw_t_q <= sens_i.raw_temp;
      raw_p_q <= sens_i.raw_press;
      raw_h_q <= sens_i.raw_hum;
    end
    if (state_q == ST_RUN) begin
      if (step_done && wb_en) begin
        rf_q[ins.dst] <= wb_val;
      end
      // 64-bit product from three 32x32 partial products
      if (ins.op == esc_pkg::OP_MUL) begin
        case (cnt_q[1:0])
          2'd0: prod_q <= a_val[31:0] * b_val[31:0];
          2'd1: begin
            acc_q  <= prod_q;
            prod_q <= a_val[31:0] * b_val[63:32];
          end
          2'd2: begin
            acc_q  <= acc_q + {prod_q[31:0], 32'd0};
            prod_q <= a_val[63:32] * b_val[31:0];
          end
          default: ;
        endcase
      end
      // restoring divide on magnitudes, one quotient bit a cycle
      if (ins.op == esc_pkg::OP_DIV) begin
        if (cnt_q == 7'd0) begin
          dv_quo_q  <= a_val[63] ? (64'd0 - a_val) : a_val;
          dv_den_q  <= b_val[63] ? (64'd0 - b_val) : b_val;
          dv_rem_q  <= '0;
          dv_neg_q  <= a_val[63] ^ b_val[63];
          dv_zero_q <= (b_val == 64'sd0);
        end else if (cnt_q <= 7'd64) begin
          if (rem_sh >= {1'b0, dv_den_q}) begin
            dv_rem_q <= 64'(rem_sh - {1'b0, dv_den_q});
            dv_quo_q <= {dv_quo_q[62:0], 1'b1};
          end else begin
            dv_rem_q <= rem_sh[63:0];
            dv_quo_q <= {dv_quo_q[62:0], 1'b0};
          end
        end
      end
      if (ins.op == esc_pkg::OP_END && step_done) begin
        res_o.temp_valid  <= (raw_t_q != esc_pkg::TEMP_INVALID);
        res_o.temp_centi  <= (raw_t_q != esc_pkg::TEMP_INVALID) ? rf_q[7][31:0] : 32'sd0;
        res_o.press_valid <= (rf_q[6] != 64'sd0);
        res_o.press_q24_8 <= (rf_q[6] != 64'sd0) ? rf_q[5] : 64'sd0;
        res_o.hum_valid   <= (raw_h_q != esc_pkg::HUM_INVALID);
        res_o.hum_q22_10  <= (raw_h_q != esc_pkg::HUM_INVALID) ? rf_q[4][16:0] : 17'd0;
      end
    end
  end

  assign res_o.valid = out_vld_q;

endmodule
